/* sv/jsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Kinds of work that the front hands to the back.
    localparam logic [1:0] KIND_BYTE = 2'd0;  // one literal byte
    localparam logic [1:0] KIND_UCS  = 2'd1;  // code point, 1 to 3 UTF-8 bytes
    localparam logic [1:0] KIND_DONE = 2'd2;  // closing quote
    localparam logic [1:0] KIND_EOS  = 2'd3;  // zero byte, end of stream

    // Status codes of a result word.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEX = 2'd1;
    localparam logic [1:0] STATUS_EOS     = 2'd2;

    // UTF-8 boundaries and lead and trail marks.
    localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;
    localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_TRAIL     = 8'h80;

    // One queued command.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        bad;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/jsu_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   in_byte,
    output logic              push,
    output jsu_pkg::cmd_t     push_cmd
);
    import jsu_pkg::*;

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_point_reg, code_point_next;
    logic        bad_reg, bad_next;

    logic [7:0]  upper;
    logic [3:0]  digit;
    logic        digit_ok;
    logic [15:0] cp_upd;
    logic        bad_upd;

    // Hex digit decode, either case.
    always_comb
    begin
        upper    = in_byte & 8'hDF;
        digit    = 4'd0;
        digit_ok = 1'b0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            digit    = in_byte[3:0];
            digit_ok = 1'b1;
        end
        else if (upper >= 8'h41 && upper <= 8'h46)
        begin
            digit    = upper[3:0] + 4'd9;
            digit_ok = 1'b1;
        end
        cp_upd  = digit_ok ? {code_point_reg[11:0], digit} : code_point_reg;
        bad_upd = bad_reg | ~digit_ok;
    end

    // Escape state machine; each accepted byte may queue one command.
    always_comb
    begin
        mode_next       = mode_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        bad_next        = bad_reg;
        push            = 1'b0;
        push_cmd        = '0;
        if (accept)
        begin
            if (in_byte == CH_NUL)
            begin
                mode_next       = MODE_TEXT;
                hex_count_next  = 2'd0;
                code_point_next = 16'd0;
                bad_next        = 1'b0;
                push            = 1'b1;
                push_cmd.kind   = KIND_EOS;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_ESC:
                    begin
                        mode_next     = MODE_TEXT;
                        push          = 1'b1;
                        push_cmd.kind = KIND_BYTE;
                        unique case (in_byte)
                            CH_B:    push_cmd.value = 16'h0008;
                            CH_F:    push_cmd.value = 16'h000C;
                            CH_N:    push_cmd.value = 16'h000A;
                            CH_R:    push_cmd.value = 16'h000D;
                            CH_T:    push_cmd.value = 16'h0009;
                            CH_U:
                            begin
                                mode_next       = MODE_HEX;
                                hex_count_next  = 2'd0;
                                code_point_next = 16'd0;
                                bad_next        = 1'b0;
                                push            = 1'b0;
                            end
                            default: push_cmd.value = {8'd0, in_byte};
                        endcase
                    end
                    MODE_HEX:
                    begin
                        if (hex_count_reg != 2'd3)
                        begin
                            hex_count_next  = hex_count_reg + 2'd1;
                            code_point_next = cp_upd;
                            bad_next        = bad_upd;
                        end
                        else
                        begin
                            mode_next       = MODE_TEXT;
                            hex_count_next  = 2'd0;
                            code_point_next = 16'd0;
                            bad_next        = 1'b0;
                            push            = 1'b1;
                            push_cmd.kind   = KIND_UCS;
                            push_cmd.value  = cp_upd;
                            push_cmd.bad    = bad_upd;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_TEXT;
                        if (in_byte == CH_BSLSH)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else if (in_byte == CH_QUOTE)
                        begin
                            hex_count_next  = 2'd0;
                            code_point_next = 16'd0;
                            bad_next        = 1'b0;
                            push            = 1'b1;
                            push_cmd.kind   = KIND_DONE;
                        end
                        else
                        begin
                            push           = 1'b1;
                            push_cmd.kind  = KIND_BYTE;
                            push_cmd.value = {8'd0, in_byte};
                        end
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_TEXT;
            hex_count_reg  <= 2'd0;
            code_point_reg <= 16'd0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
            bad_reg        <= bad_next;
        end
    end

    // The digit counter only runs inside a hex escape.
    a_count_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        hex_count_reg != 2'd0 |-> mode_reg == MODE_HEX)
        else $error("hex digit count outside a hex escape");

    // A completed hex escape always queues a code point.
    a_hex_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_HEX && hex_count_reg == 2'd3 && in_byte != CH_NUL
        |-> push && push_cmd.kind == KIND_UCS)
        else $error("completed hex escape queued no code point");

    // Bytes that are only prefixes queue nothing.
    a_prefix_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_TEXT && in_byte == CH_BSLSH |-> !push)
        else $error("backslash queued a command");

endmodule

`default_nettype wire

/* sv/jsu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  jsu_pkg::cmd_t     push_cmd,
    output logic              full,
    input  wire logic         pop,
    output jsu_pkg::cmd_t     head_cmd,
    output logic              empty
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

/* sv/jsu_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  jsu_pkg::cmd_t     head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        out_byte,
    output logic              has_byte,
    output logic              string_done,
    output logic [1:0]        status,
    output logic              last_of_run
);
    import jsu_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        has_reg, done_reg, last_reg;
    logic [1:0]  status_reg;

    logic [1:0]  n_words;
    logic [15:0] cp;
    logic [7:0]  w_byte;
    logic        w_has, w_done, w_last;
    logic [1:0]  w_status;
    logic        load;

    // Build the word at the current index of the head command.
    always_comb
    begin
        cp       = head_cmd.value;
        n_words  = (cp < UTF8_TWO_MIN) ? 2'd1 : ((cp < UTF8_THREE_MIN) ? 2'd2 : 2'd3);
        w_byte   = 8'd0;
        w_has    = 1'b0;
        w_done   = 1'b0;
        w_status = STATUS_OK;
        w_last   = 1'b1;
        unique case (head_cmd.kind)
            KIND_BYTE:
            begin
                w_byte = cp[7:0];
                w_has  = 1'b1;
            end
            KIND_UCS:
            begin
                w_has    = 1'b1;
                w_status = head_cmd.bad ? STATUS_BAD_HEX : STATUS_OK;
                w_last   = (idx_reg == n_words - 2'd1);
                if (n_words == 2'd1)
                begin
                    w_byte = cp[7:0];
                end
                else if (n_words == 2'd2)
                begin
                    w_byte = (idx_reg == 2'd0) ? (UTF8_LEAD2 | {3'd0, cp[10:6]})
                                               : (UTF8_TRAIL | {2'd0, cp[5:0]});
                end
                else
                begin
                    case (idx_reg)
                        2'd0:    w_byte = UTF8_LEAD3 | {4'd0, cp[15:12]};
                        2'd1:    w_byte = UTF8_TRAIL | {2'd0, cp[11:6]};
                        default: w_byte = UTF8_TRAIL | {2'd0, cp[5:0]};
                    endcase
                end
            end
            KIND_DONE:
            begin
                w_done = 1'b1;
            end
            default:
            begin
                w_status = STATUS_EOS;
            end
        endcase
    end

    // Load the output register when it is empty or being drained.
    always_comb
    begin
        load           = head_valid && (!out_valid_reg || out_ready);
        pop            = load && w_last;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = w_last ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= w_byte;
            has_reg    <= w_has;
            done_reg   <= w_done;
            status_reg <= w_status;
            last_reg   <= w_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign has_byte    = has_reg;
    assign string_done = done_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

    // A partly expanded command stays at the head of the queue.
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> head_valid && head_cmd.kind == KIND_UCS)
        else $error("expansion index set without a code point at the head");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("expansion index out of range");

    // A word that ends its run always pops its command.
    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        load && w_last |-> pop)
        else $error("last word did not retire its command");

endmodule

`default_nettype wire

/* sv/json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
`default_nettype none
// Commands of accepted bytes are queued, then turned into words in the output register.
// Throughput: one byte in per cycle; one word out per cycle while out_ready is high.
// A hex escape yields up to three words but needs six input bytes, so the queue keeps up.
// Input stalls only when the command queue between the front and back is full.
// Reset (rst_n low, asynchronous) clears the escape state, the queue and the output.

module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            string_done,
    output logic [1:0]      status,
    output logic            last_of_run
);
    import jsu_pkg::*;

    logic accept;
    logic push, pop, full, empty;
    cmd_t push_cmd, head_cmd;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // Front: escape decoding.
    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue.
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    // Back: word expansion and output register.
    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (!empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .string_done (string_done),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    import jsu_pkg::*;

    localparam int RAND_ITEMS = 350;

    // Characters with a meaning inside a string body.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Control bytes that the short escapes stand for.
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    localparam logic [7:0] UTF8_PAYLOAD = 8'h3F;

    typedef enum logic [1:0] {ST_PLAIN, ST_AFTER_BSLASH, ST_UCS} scan_state_e;

    // One output word as seen on the result port.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       done;
        logic [1:0] st;
        logic       last;
    } dec_word_t;

    // One stimulus byte; a hand-written word replaces the prediction when set.
    typedef struct packed {
        logic [7:0] b;
        logic       hand;
        dec_word_t  w;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic [1:0] status;
    logic       last_of_run;

    int idle_in = 0;
    int idle_out = 0;
    int n_sent = 0;
    int n_words = 0;
    int n_ucs = 0;
    int n_flagged = 0;
    int faults = 0;

    dec_word_t want_words[$];
    row_t      sent_rows[$];

    // Decoder state kept by the testbench.
    scan_state_e scan_state;
    logic [1:0]  digit_cnt;
    logic [15:0] ucs_acc;
    logic        ucs_bad;

    json_string_unescape_utf8 DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .string_done (string_done),
        .status      (status),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    // Timeout guard.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Value of a hex digit, or -1 when the character is not one.
    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic dec_word_t mk_word(input logic [7:0] data, input logic has,
                                          input logic done, input logic [1:0] st,
                                          input logic last);
        dec_word_t w;
        w.data = data;
        w.has = has;
        w.done = done;
        w.st = st;
        w.last = last;
        return w;
    endfunction

    function automatic row_t plain(input logic [7:0] b);
        row_t r;
        r.b = b;
        r.hand = 1'b0;
        r.w = '0;
        return r;
    endfunction

    function automatic row_t hand(input logic [7:0] b, input logic [7:0] data,
                                  input logic has, input logic done,
                                  input logic [1:0] st);
        row_t r;
        r.b = b;
        r.hand = 1'b1;
        r.w = mk_word(data, has, done, st, 1'b1);
        return r;
    endfunction

    task automatic clear_scan();
        scan_state = ST_PLAIN;
        digit_cnt = 2'd0;
        ucs_acc = 16'h0000;
        ucs_bad = 1'b0;
    endtask

    // Works out the words that one accepted byte causes.
    task automatic decode_byte(input logic [7:0] b);
        int          d;
        logic [7:0]  o;
        logic [15:0] c;
        logic [1:0]  st;
        if (b == CH_NUL)
        begin
            clear_scan();
            want_words.push_back(mk_word(8'h00, 1'b0, 1'b0, STATUS_EOS, 1'b1));
            return;
        end
        case (scan_state)
            ST_AFTER_BSLASH:
            begin
                case (b)
                    CH_B: o = CTL_BS;
                    CH_F: o = CTL_FF;
                    CH_N: o = CTL_LF;
                    CH_R: o = CTL_CR;
                    CH_T: o = CTL_HT;
                    CH_U:
                    begin
                        scan_state = ST_UCS;
                        digit_cnt = 2'd0;
                        ucs_acc = 16'h0000;
                        ucs_bad = 1'b0;
                        return;
                    end
                    default: o = b;
                endcase
                scan_state = ST_PLAIN;
                want_words.push_back(mk_word(o, 1'b1, 1'b0, STATUS_OK, 1'b1));
            end
            ST_UCS:
            begin
                d = hex_digit(b);
                if (d < 0)
                    ucs_bad = 1'b1;
                else
                    ucs_acc = {ucs_acc[11:0], 4'(d)};
                if (digit_cnt != 2'd3)
                begin
                    digit_cnt = digit_cnt + 2'd1;
                    return;
                end
                c = ucs_acc;
                st = ucs_bad ? STATUS_BAD_HEX : STATUS_OK;
                n_ucs++;
                clear_scan();
                // Encode the code point as one, two or three UTF-8 bytes.
                if (c < UTF8_TWO_MIN)
                begin
                    want_words.push_back(mk_word(c[7:0], 1'b1, 1'b0, st, 1'b1));
                end
                else if (c < UTF8_THREE_MIN)
                begin
                    want_words.push_back(mk_word(UTF8_LEAD2 | 8'(c >> 6),
                                                 1'b1, 1'b0, st, 1'b0));
                    want_words.push_back(mk_word(UTF8_TRAIL | (c[7:0] & UTF8_PAYLOAD),
                                                 1'b1, 1'b0, st, 1'b1));
                end
                else
                begin
                    want_words.push_back(mk_word(UTF8_LEAD3 | 8'(c >> 12),
                                                 1'b1, 1'b0, st, 1'b0));
                    want_words.push_back(mk_word(UTF8_TRAIL | (8'(c >> 6) & UTF8_PAYLOAD),
                                                 1'b1, 1'b0, st, 1'b0));
                    want_words.push_back(mk_word(UTF8_TRAIL | (c[7:0] & UTF8_PAYLOAD),
                                                 1'b1, 1'b0, st, 1'b1));
                end
            end
            default:
            begin
                if (b == CH_BSLASH)
                begin
                    scan_state = ST_AFTER_BSLASH;
                end
                else if (b == CH_QUOTE)
                begin
                    clear_scan();
                    want_words.push_back(mk_word(8'h00, 1'b0, 1'b1, STATUS_OK, 1'b1));
                end
                else
                begin
                    scan_state = ST_PLAIN;
                    want_words.push_back(mk_word(b, 1'b1, 1'b0, STATUS_OK, 1'b1));
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input dec_word_t want,
                                   input dec_word_t got);
        faults++;
        if (faults <= 10)
        begin
            $display("%0t: %s: want byte %02h has %0b done %0b status %0d last %0b,",
                     $realtime, what, want.data, want.has, want.done, want.st, want.last);
            $display("    got byte %02h has %0b done %0b status %0d last %0b",
                     got.data, got.has, got.done, got.st, got.last);
        end
    endtask

    // Prediction on accepted bytes, then checking of accepted words.
    always @(posedge clk)
    begin
        dec_word_t got;
        dec_word_t want;
        row_t      note;
        int        n0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                note = sent_rows.pop_front();
                n0 = want_words.size();
                decode_byte(in_byte);
                if (note.hand)
                begin
                    while (want_words.size() > n0)
                        void'(want_words.pop_back());
                    want_words.push_back(note.w);
                end
            end
            if (out_valid && out_ready)
            begin
                got = {out_byte, has_byte, string_done, status, last_of_run};
                n_words++;
                if (got.st == STATUS_BAD_HEX)
                    n_flagged++;
                if (want_words.size() == 0)
                begin
                    report_mismatch("word with nothing expected", '0, got);
                end
                else
                begin
                    want = want_words.pop_front();
                    if (got !== want)
                        report_mismatch("word mismatch", want, got);
                end
            end
        end
    end

    // Receiver stalls.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= idle_out);

    task automatic send_row(input row_t r);
        while ($urandom_range(99) < idle_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= r.b;
        sent_rows.push_back(r);
        n_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_row(plain(b));
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
    endfunction

    // Any nonzero byte that is not a hex digit, a quote now and then.
    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        if ($urandom_range(3) == 0)
            return CH_QUOTE;
        do
            c = 8'($urandom_range(1, 255));
        while (hex_digit(c) >= 0);
        return c;
    endfunction

    // A unicode escape with four digits, one of them bad now and then.
    task automatic send_ucs();
        logic [15:0] cp;
        int          bad_at;
        case ($urandom_range(3))
            0: cp = 16'($urandom_range(0, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            default:
            begin
                case ($urandom_range(5))
                    0: cp = 16'h0000;
                    1: cp = 16'h007F;
                    2: cp = 16'h0080;
                    3: cp = 16'h07FF;
                    4: cp = 16'h0800;
                    default: cp = 16'hFFFF;
                endcase
            end
        endcase
        bad_at = ($urandom_range(99) < 15) ? $urandom_range(3) : -1;
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 0; i < 4; i++)
        begin
            if (i == bad_at)
                send_byte(non_hex());
            else
                send_byte(hex_char(int'(cp[15 - 4 * i -: 4])));
        end
    endtask

    // One random piece of a string body.
    task automatic send_token();
        int         r;
        int         k;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 35)
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == CH_BSLASH || b == CH_QUOTE);
            send_byte(b);
        end
        else if (r < 55)
        begin
            send_byte(CH_BSLASH);
            case ($urandom_range(8))
                0: send_byte(CH_B);
                1: send_byte(CH_F);
                2: send_byte(CH_N);
                3: send_byte(CH_R);
                4: send_byte(CH_T);
                5: send_byte(CH_QUOTE);
                6: send_byte(CH_BSLASH);
                7: send_byte(CH_SLASH);
                default: send_byte(8'($urandom_range(1, 255)));
            endcase
        end
        else if (r < 85)
        begin
            send_ucs();
        end
        else if (r < 93)
        begin
            send_byte(CH_QUOTE);
        end
        else if (r < 96)
        begin
            send_byte(CH_NUL);
        end
        else
        begin
            // Unicode escape cut short; later bytes land in its digit slots.
            send_byte(CH_BSLASH);
            send_byte(CH_U);
            k = $urandom_range(3);
            for (int i = 0; i < k; i++)
                send_byte(hex_char($urandom_range(15)));
        end
    endtask

    // Stimulus.
    initial
    begin
        row_t plan [30];
        int   goal;
        plan = '{
            hand(8'h41, 8'h41, 1'b1, 1'b0, STATUS_OK),
            hand(8'hFF, 8'hFF, 1'b1, 1'b0, STATUS_OK),
            hand(CH_QUOTE, 8'h00, 1'b0, 1'b1, STATUS_OK),
            hand(CH_NUL, 8'h00, 1'b0, 1'b0, STATUS_EOS),
            plain(CH_BSLASH),
            hand(CH_N, CTL_LF, 1'b1, 1'b0, STATUS_OK),
            // Unknown escape letter passes through without its backslash.
            plain(CH_BSLASH),
            plain("q"),
            // Code point zero comes out as one zero byte.
            plain(CH_BSLASH), plain(CH_U), plain("0"), plain("0"), plain("0"),
            hand("0", 8'h00, 1'b1, 1'b0, STATUS_OK),
            // Top of the two-byte range, mixed case digits.
            plain(CH_BSLASH), plain(CH_U), plain("0"), plain("7"), plain("f"),
            plain("F"),
            // Quote in a digit slot is a bad digit; three bytes flagged.
            plain(CH_BSLASH), plain(CH_U), plain("F"), plain("f"), plain(CH_QUOTE),
            plain("1"),
            // End of stream in the middle of an escape.
            plain(CH_BSLASH), plain(CH_U), plain("1"),
            hand(CH_NUL, 8'h00, 1'b0, 1'b0, STATUS_EOS)
        };
        clear_scan();
        idle_in = 35;
        idle_out = 79;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        foreach (plan[i])
            send_row(plan[i]);

        // Random part in three idling phases.
        goal = n_sent + RAND_ITEMS;
        while (n_sent < goal)
        begin
            if (n_sent >= goal - RAND_ITEMS / 3)
            begin
                idle_in = 0;
                idle_out = 0;
            end
            else if (n_sent >= goal - 2 * RAND_ITEMS / 3)
            begin
                idle_in = 79;
                idle_out = 35;
            end
            send_token();
        end
        in_valid <= 1'b0;

        // Drain and let the pipeline settle.
        while (want_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d string bytes and checked %0d output words.", n_sent, n_words);
        $display("Covered %0d unicode escapes, %0d words flagged bad hex, %0d mismatches.",
                 n_ucs, n_flagged, faults);
        if (faults == 0 && want_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
